/* src/sha_pkg.sv */
package sha_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // word source for the datapath
    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    typedef struct packed {
        logic      clear_len;
        logic      add_len;
        logic [2:0] len_bytes;
        logic      push;
        word_src_t src;
        logic      pad_msg;
        logic [2:0] pad_bytes;
        logic      load_vars;
        logic      round_en;
        logic [5:0] round;
        logic      fold;
        logic      reset_chain;
        logic      out_shift;
    } sha_cmd_t;

    typedef struct packed {
        logic [3:0] word_count;
    } sha_stat_t;

endpackage

/* src/sha256_stream_hash.sv */
// channel | fields (low bit up)                        | handshake
// s_      | tdata: msg_word[31:0], valid_bytes[34:32]; tlast: last_word | s_tvalid/s_tready
// m_      | tdata: digest_word[31:0], word_index[34:32]; tlast: digest_done | m_tvalid/m_tready
// One word a cycle into the block buffer while s_tready is high; each full block then
// runs load, 64 rounds of the single round unit, and fold.
// A last word adds padding words, one or two blocks, then eight digest words.
// aresetn is synchronous, active low; s_tready is low while a block, the padding or the digest is busy.
// m_tvalid holds until each digest word is taken.
module sha256_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // msg_word, valid_bytes, zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // digest_word, word_index, zero fill
    output logic        m_tlast
);
    import sha_pkg::*;

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] head_word;
    logic [2:0]  out_index;

    sha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bytes  (s_tdata[34:32]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_done  (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    sha_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_tdata[31:0]),
        .head_word (head_word)
    );

    assign m_tdata = {5'd0, out_index, head_word};

endmodule

/* src/sha_datapath.sv */
module sha_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::sha_cmd_t cmd,
    output sha_pkg::sha_stat_t stat,
    input  logic [31:0]       in_word,
    output logic [31:0]       head_word
);
    import sha_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] win_reg [16];
    logic [3:0]  cnt_reg;
    logic [60:0] len_reg;

    logic [31:0] keep, padded, push_w, bits_hi, bits_lo;
    logic [31:0] x15, x2, sg0, sg1, wnew, w, big1, chs, t1, big0, mj, t2;
    logic [63:0] bits;

    assign bits    = {len_reg, 3'b000};
    assign bits_hi = bits[63:32];
    assign bits_lo = bits[31:0];

    always_comb begin
        keep = 32'hffff_ffff;
        case (cmd.pad_bytes)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hff00_0000;
            3'd2:    keep = 32'hffff_0000;
            3'd3:    keep = 32'hffff_ff00;
            default: keep = 32'hffff_ffff;
        endcase
        padded = in_word & keep;
        case (cmd.pad_bytes)
            3'd0:    padded = padded | {PAD_BYTE, 24'd0};
            3'd1:    padded = padded | {8'd0, PAD_BYTE, 16'd0};
            3'd2:    padded = padded | {16'd0, PAD_BYTE, 8'd0};
            3'd3:    padded = padded | {24'd0, PAD_BYTE};
            default: padded = padded;
        endcase
        case (cmd.src)
            SRC_MSG:    push_w = cmd.pad_msg ? padded : in_word;
            SRC_ZERO:   push_w = cmd.pad_msg ? PAD_WORD : 32'd0;
            SRC_LEN_HI: push_w = bits_hi;
            SRC_LEN_LO: push_w = bits_lo;
            default:    push_w = 32'd0;
        endcase
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int r);
        ror = (x >> r) | (x << (32 - r));
    endfunction

    always_comb begin
        x15  = win_reg[4'(cmd.round + 6'd1)];
        x2   = win_reg[4'(cmd.round + 6'd14)];
        sg0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        sg1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        wnew = win_reg[cmd.round[3:0]] + sg0 + win_reg[4'(cmd.round + 6'd9)] + sg1;
        w    = (cmd.round >= 6'd16) ? wnew : win_reg[cmd.round[3:0]];
        big1 = ror(var_reg[4], 6) ^ ror(var_reg[4], 11) ^ ror(var_reg[4], 25);
        chs  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1   = var_reg[7] + big1 + chs + ROUND_K[cmd.round] + w;
        big0 = ror(var_reg[0], 2) ^ ror(var_reg[0], 13) ^ ror(var_reg[0], 22);
        mj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]);
        t2   = big0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            win_reg[cnt_reg] <= push_w;
        end else if (cmd.round_en) begin
            win_reg[cmd.round[3:0]] <= w;
        end
        if (cmd.load_vars) begin
            var_reg <= chain_reg;
        end else if (cmd.round_en) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= H_INIT;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end else begin
            if (cmd.push) begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (cmd.clear_len) begin
                len_reg <= '0;
            end else if (cmd.add_len) begin
                len_reg <= len_reg + 61'(cmd.len_bytes);
            end
            if (cmd.reset_chain) begin
                chain_reg <= H_INIT;
            end else if (cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end else if (cmd.out_shift) begin
                for (int i = 0; i < 7; i++) begin
                    chain_reg[i] <= chain_reg[i+1];
                end
                chain_reg[7] <= chain_reg[0];
            end
        end
    end

    assign stat.word_count = cnt_reg;
    assign head_word       = chain_reg[0];

endmodule

/* src/sha_ctrl.sv */
module sha_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_bytes,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_index,
    output logic               out_done,
    output sha_pkg::sha_cmd_t  cmd,
    input  sha_pkg::sha_stat_t stat
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       fin_reg, fin_next;   // in final padding
    logic       mark_reg, mark_next; // 0x80 word still owed
    logic       lenw_reg, lenw_next; // low length word next
    logic [2:0] idx_reg, idx_next;
    logic [2:0] nb;

    assign nb = (in_bytes > 3'd4) ? 3'd4 : in_bytes;

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        lenw_next  = lenw_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.src    = SRC_MSG;
        cmd.round  = round_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.push      = 1'b1;
                    cmd.add_len   = 1'b1;
                    cmd.len_bytes = in_last ? nb : 3'd4;
                    cmd.pad_msg   = in_last;
                    cmd.pad_bytes = in_last ? nb : 3'd4;
                    fin_next      = in_last;
                    mark_next     = in_last && (nb == 3'd4);
                    lenw_next     = 1'b0;
                    if (stat.word_count == 4'd15) begin
                        state_next = ST_LOAD;
                    end else if (in_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                if (mark_reg) begin
                    cmd.src     = SRC_ZERO;
                    cmd.pad_msg = 1'b1;
                    mark_next   = 1'b0;
                end else if (lenw_reg) begin
                    cmd.src = SRC_LEN_LO;
                end else if (stat.word_count == 4'd14) begin
                    cmd.src   = SRC_LEN_HI;
                    lenw_next = 1'b1;
                end else begin
                    cmd.src = SRC_ZERO;
                end
                if (stat.word_count == 4'd15) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_vars = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (lenw_reg) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.out_shift   = 1'b0;
                        cmd.reset_chain = 1'b1;
                        cmd.clear_len   = 1'b1;
                        fin_next        = 1'b0;
                        lenw_next       = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_index = idx_reg;
    assign out_done  = (idx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenw_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            lenw_reg  <= lenw_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready)
        else $error("input taken during digest output");
    a_round_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count did not end block");
    a_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> stat.word_count == 4'd0)
        else $error("block compressed while not full");
`endif

endmodule
